// File: sv/aptt_pkg.sv
// Shared types and constants for the affine point / tensor transform.
// Used by aptt_matmul and affine_point_tensor_transform; no dependencies.
`default_nettype none

package aptt_pkg;

  localparam int unsigned CoefW    = 16;  // Q4.12 coefficient
  localparam int unsigned CompW    = 32;  // Q16.16 component
  localparam int unsigned FracBits = 12;
  localparam int unsigned RowW     = 3 * CoefW;
  localparam int unsigned CfgIdxW  = 3;

  // Width of a rounded 3-term product sum for given operand widths
  localparam int unsigned TW = CoefW + CompW + 2 - FracBits;  // L * A
  localparam int unsigned WW = TW + CoefW + 2 - FracBits;     // (L * A) * L^T

  localparam logic [1:0] MODE_POINT  = 2'd0;
  localparam logic [1:0] MODE_VECTOR = 2'd1;
  localparam logic [1:0] MODE_TENSOR = 2'd2;
  localparam logic [1:0] MODE_PASS   = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_ROW0      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW1      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW2      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_Z   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_POINT_DIM = 3'd6;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [CompW-1:0] comp_0;
    logic signed [CompW-1:0] comp_1;
    logic signed [CompW-1:0] comp_2;
    logic signed [CompW-1:0] comp_3;
    logic signed [CompW-1:0] comp_4;
    logic signed [CompW-1:0] comp_5;
    logic signed [CompW-1:0] comp_6;
    logic signed [CompW-1:0] comp_7;
    logic signed [CompW-1:0] comp_8;
    logic                    last_item;
  } apt_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] res_0;
    logic signed [CompW-1:0] res_1;
    logic signed [CompW-1:0] res_2;
    logic signed [CompW-1:0] res_3;
    logic signed [CompW-1:0] res_4;
    logic signed [CompW-1:0] res_5;
    logic signed [CompW-1:0] res_6;
    logic signed [CompW-1:0] res_7;
    logic signed [CompW-1:0] res_8;
    logic                    saturated;
    logic                    last_out;
  } apt_out_t;

endpackage

`default_nettype wire

// File: sv/aptt_matmul.sv
// Two-stage 3x3 by 3x3 fixed-point matrix product, C = round12(X * Y).
// Stage one registers the 27 products, stage two the rounded sums. Uses aptt_pkg.
`default_nettype none

module aptt_matmul import aptt_pkg::*; #(
  parameter int unsigned AW = CoefW,
  parameter int unsigned BW = CompW
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [AW-1:0]          x_i [3][3],
  input  wire logic signed [BW-1:0]          y_i [3][3],
  output      logic signed [AW+BW+1-FracBits:0] c_o [3][3]
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned CW = SW - FracBits;
  localparam logic signed [SW-1:0] Half = SW'(1) << (FracBits - 1);

  logic signed [PW-1:0] prod_q [3][3][3];
  logic signed [SW-1:0] sum    [3][3];
  logic signed [CW-1:0] c_d    [3][3];
  logic signed [CW-1:0] c_q    [3][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          for (int k = 0; k < 3; k++) begin
            prod_q[r][c][k] <= PW'(x_i[r][k]) * PW'(y_i[k][c]);
          end
        end
      end
    end
  end

  // Round half up: add one half LSB, then arithmetic shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum[r][c] = SW'(prod_q[r][c][0]) + SW'(prod_q[r][c][1]) + SW'(prod_q[r][c][2]) + Half;
        c_d[r][c] = CW'(sum[r][c] >>> FracBits);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

`default_nettype wire

// File: sv/affine_point_tensor_transform.sv
// Affine point / vector / tensor transform, top level. Uses aptt_pkg and aptt_matmul.
// Beats pass u_first, u_second, the result register; one beat per cycle unless held.
// The pipeline advances as a whole; it holds only while the result register waits.
// Reset clears all valid bits, loads the identity matrix, zero translation and
// point_dim 3. Configuration writes complete in the cycle they are offered.
`default_nettype none

module affine_point_tensor_transform import aptt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire apt_in_t            in_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      apt_out_t           out_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [RowW-1:0]    cfg_data_i
);

  localparam int unsigned SatW = WW + 1;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  last;
    logic [8:0][CompW-1:0] comp;
  } side_t;

  // Configuration
  logic [RowW-1:0]         row_q   [3];
  logic signed [CompW-1:0] shift_q [3];
  logic [1:0]              pd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= RowW'(4096);
      row_q[1]   <= RowW'(4096) << CoefW;
      row_q[2]   <= RowW'(4096) << (2 * CoefW);
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
      pd_q       <= 2'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROW0:      row_q[0]   <= cfg_data_i;
        REG_ROW1:      row_q[1]   <= cfg_data_i;
        REG_ROW2:      row_q[2]   <= cfg_data_i;
        REG_SHIFT_X:   shift_q[0] <= cfg_data_i[CompW-1:0];
        REG_SHIFT_Y:   shift_q[1] <= cfg_data_i[CompW-1:0];
        REG_SHIFT_Z:   shift_q[2] <= cfg_data_i[CompW-1:0];
        REG_POINT_DIM: pd_q       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [CoefW-1:0] lmat [3][3];
  logic signed [CoefW-1:0] ltr  [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        lmat[r][k] = row_q[r][CoefW*k +: CoefW];
        ltr[k][r]  = row_q[r][CoefW*k +: CoefW];
      end
    end
  end

  // Pipeline control: every stage moves together
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Operand matrix: tensor as is, point or vector in column 0
  logic signed [CompW-1:0] a    [9];
  logic signed [CompW-1:0] bmat [3][3];

  assign a[0] = in_i.comp_0;
  assign a[1] = in_i.comp_1;
  assign a[2] = in_i.comp_2;
  assign a[3] = in_i.comp_3;
  assign a[4] = in_i.comp_4;
  assign a[5] = in_i.comp_5;
  assign a[6] = in_i.comp_6;
  assign a[7] = in_i.comp_7;
  assign a[8] = in_i.comp_8;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        bmat[k][c] = '0;
      end
    end
    case (in_i.mode)
      MODE_POINT: begin
        for (int k = 0; k < 3; k++) begin
          if (k < int'(pd_q)) begin
            bmat[k][0] = a[k];
          end
        end
      end
      MODE_VECTOR: begin
        for (int k = 0; k < 3; k++) begin
          bmat[k][0] = a[k];
        end
      end
      MODE_TENSOR: begin
        for (int k = 0; k < 3; k++) begin
          for (int c = 0; c < 3; c++) begin
            bmat[k][c] = a[3*k+c];
          end
        end
      end
      default: ;
    endcase
  end

  logic signed [TW-1:0] tmat [3][3];
  logic signed [WW-1:0] wmat [3][3];

  aptt_matmul #(
    .AW (CoefW),
    .BW (CompW)
  ) u_first (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (lmat),
    .y_i   (bmat),
    .c_o   (tmat)
  );

  aptt_matmul #(
    .AW (TW),
    .BW (CoefW)
  ) u_second (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (tmat),
    .y_i   (ltr),
    .c_o   (wmat)
  );

  // Sideband travels alongside the matrix stages
  side_t side1_q, side2_q, side3_q, side4_q;
  logic signed [TW-1:0] t0_q [3];
  logic signed [TW-1:0] t1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q.mode <= in_i.mode;
      side1_q.last <= in_i.last_item;
      for (int k = 0; k < 9; k++) begin
        side1_q.comp[k] <= a[k];
      end
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      for (int r = 0; r < 3; r++) begin
        t0_q[r] <= tmat[r][0];
        t1_q[r] <= t0_q[r];
      end
    end
  end

  // Final stage: select, translate, clamp
  logic signed [SatW-1:0]  val  [9];
  logic                    keep [9];
  logic [8:0][CompW-1:0]   res_d;
  logic                    sat_d;
  apt_out_t                out_d, out_q;

  always_comb begin
    sat_d = 1'b0;
    for (int k = 0; k < 9; k++) begin
      val[k]  = '0;
      keep[k] = 1'b0;
    end
    case (side4_q.mode)
      MODE_POINT: begin
        for (int r = 0; r < 3; r++) begin
          if (r < int'(pd_q)) begin
            val[r]  = SatW'(t1_q[r]) + SatW'(shift_q[r]);
            keep[r] = 1'b1;
          end
        end
      end
      MODE_VECTOR: begin
        for (int r = 0; r < 3; r++) begin
          val[r]  = SatW'(t1_q[r]);
          keep[r] = 1'b1;
        end
      end
      MODE_TENSOR: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            val[3*r+c]  = SatW'(wmat[r][c]);
            keep[3*r+c] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    for (int k = 0; k < 9; k++) begin
      if (side4_q.mode == MODE_PASS) begin
        res_d[k] = side4_q.comp[k];
      end else if (!keep[k]) begin
        res_d[k] = '0;
      end else if (!((&val[k][SatW-1:CompW-1]) || !(|val[k][SatW-1:CompW-1]))) begin
        // Upper bits disagree: clamp toward the sign
        sat_d    = 1'b1;
        res_d[k] = val[k][SatW-1] ? {1'b1, {(CompW-1){1'b0}}}
                                  : {1'b0, {(CompW-1){1'b1}}};
      end else begin
        res_d[k] = val[k][CompW-1:0];
      end
    end
    out_d.res_0     = res_d[0];
    out_d.res_1     = res_d[1];
    out_d.res_2     = res_d[2];
    out_d.res_3     = res_d[3];
    out_d.res_4     = res_d[4];
    out_d.res_5     = res_d[5];
    out_d.res_6     = res_d[6];
    out_d.res_7     = res_d[7];
    out_d.res_8     = res_d[8];
    out_d.saturated = sat_d;
    out_d.last_out  = side4_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Assertions
  a_stall_holds_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(v2_q) && $stable(v3_q) && $stable(v4_q) && out_valid_q)
    else $error("pipeline valid bits moved during a stall");

  a_advance_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v4_q |=> out_valid_q)
    else $error("beat lost on its way to the result register");

  a_pass_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v4_q && side4_q.mode == MODE_PASS |=> !out_q.saturated)
    else $error("pass-through beat flagged as saturated");

  a_empty_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v4_q && side4_q.mode == MODE_POINT && pd_q == 2'd0
    |=> !out_q.saturated && out_q.res_0 == '0 && out_q.res_2 == '0)
    else $error("point with no coordinates gave a nonzero result");

endmodule

`default_nettype wire
